// ===== hdl/itch_pkg.sv =====
// Package for the feed message field parser: field record, phase codes, layout tables.
// No dependencies.
`default_nettype none
package itch_pkg;

  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_TYPE   = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [4:0]  field_index;
    logic [63:0] field_value;
    logic [3:0]  field_bytes;
    logic        last_field;
    logic        unknown_type;
    logic        truncated;
  } field_t;

  localparam logic [3:0] ROW_NONE = 4'd15;

  // Map a type code to its layout row.
  function automatic logic [3:0] type_row(input logic [7:0] t);
    logic [3:0] r;
    unique case (t)
      8'h53: r = 4'd0;   // S
      8'h52: r = 4'd1;   // R
      8'h48: r = 4'd2;   // H
      8'h41: r = 4'd3;   // A
      8'h46: r = 4'd4;   // F
      8'h45: r = 4'd5;   // E
      8'h43: r = 4'd6;   // C
      8'h58: r = 4'd7;   // X
      8'h44: r = 4'd8;   // D
      8'h55: r = 4'd9;   // U
      8'h50: r = 4'd10;  // P
      8'h51: r = 4'd11;  // Q
      default: r = ROW_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] layout_count(input logic [3:0] r);
    logic [4:0] n;
    unique case (r)
      4'd0: n = 5'd4;   4'd1: n = 5'd17;  4'd2: n = 5'd7;  4'd3: n = 5'd8;
      4'd4: n = 5'd9;   4'd5: n = 5'd6;   4'd6: n = 5'd8;  4'd7: n = 5'd5;
      4'd8: n = 5'd4;   4'd9: n = 5'd7;   4'd10: n = 5'd9; 4'd11: n = 5'd8;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // Byte width of field f in row r; first three fields are shared by every row.
  function automatic logic [3:0] layout_width(input logic [3:0] r, input logic [4:0] f);
    logic [3:0] w;
    w = 4'd1;
    case (f)
      5'd0, 5'd1: w = 4'd2;
      5'd2: w = 4'd6;
      5'd3: w = (r == 4'd0) ? 4'd1 : 4'd8;
      default: begin
        case (r)
          4'd1: begin
            case (f)
              5'd6, 5'd15: w = 4'd4;
              5'd9: w = 4'd2;
              default: w = 4'd1;
            endcase
          end
          4'd2: w = (f == 5'd6) ? 4'd4 : 4'd1;
          4'd3, 4'd4, 4'd10: begin
            case (f)
              5'd4: w = 4'd1;
              5'd5, 5'd7: w = 4'd4;
              5'd8: w = (r == 4'd10) ? 4'd8 : 4'd4;
              default: w = 4'd8;
            endcase
          end
          4'd5: w = (f == 5'd4) ? 4'd4 : 4'd8;
          4'd6: begin
            case (f)
              5'd4, 5'd7: w = 4'd4;
              5'd6: w = 4'd1;
              default: w = 4'd8;
            endcase
          end
          4'd7: w = 4'd4;
          4'd9: w = (f == 5'd4) ? 4'd8 : 4'd4;
          4'd11: begin
            case (f)
              5'd5: w = 4'd4;
              5'd7: w = 4'd1;
              default: w = 4'd8;
            endcase
          end
          default: w = 4'd1;
        endcase
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/itch_front.sv =====
// Front end: accepts feed bytes, tracks framing and builds field records.
// Depends on itch_pkg.
`default_nettype none
module itch_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_byte,
  output logic                 rec_valid,
  output itch_pkg::field_t     rec
);

  itch_pkg::phase_t phase, phase_next;
  logic [15:0] body_length, body_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  current_type, current_type_next;
  logic [3:0]  row, row_next;
  logic [4:0]  field_number, field_number_next;
  logic [3:0]  field_byte_pos, field_byte_pos_next;
  logic [63:0] field_accum, field_accum_next;
  logic        emit;
  itch_pkg::field_t rec_d;

  // Decode one byte of framing or body.
  always_comb begin
    logic [4:0]  n;
    logic [3:0]  w;
    logic [15:0] cnt;
    logic        fin;
    logic        more;
    logic [63:0] acc;
    logic [3:0]  pos;
    phase_next          = phase;
    body_length_next    = body_length;
    byte_count_next     = byte_count;
    current_type_next   = current_type;
    row_next            = row;
    field_number_next   = field_number;
    field_byte_pos_next = field_byte_pos;
    field_accum_next    = field_accum;
    emit  = 1'b0;
    rec_d = '0;
    rec_d.msg_type = current_type;
    n   = itch_pkg::layout_count(row);
    w   = itch_pkg::layout_width(row, field_number);
    cnt = byte_count + 16'd1;
    fin = (cnt == body_length);
    more = (field_number + 5'd1) < n;
    acc = {field_accum[55:0], in_byte};
    pos = field_byte_pos + 4'd1;
    unique case (phase)
      itch_pkg::PH_LEN_HI: begin
        body_length_next = {in_byte, 8'd0};
        phase_next = itch_pkg::PH_LEN_LO;
      end
      itch_pkg::PH_LEN_LO: begin
        body_length_next = {body_length[15:8], in_byte};
        byte_count_next = '0;
        phase_next = ({body_length[15:8], in_byte} == 16'd0) ?
                     itch_pkg::PH_LEN_HI : itch_pkg::PH_TYPE;
      end
      itch_pkg::PH_TYPE: begin
        current_type_next   = in_byte;
        row_next            = itch_pkg::type_row(in_byte);
        byte_count_next     = 16'd1;
        field_number_next   = '0;
        field_byte_pos_next = '0;
        field_accum_next    = '0;
        rec_d.msg_type   = in_byte;
        rec_d.last_field = 1'b1;
        if (itch_pkg::type_row(in_byte) == itch_pkg::ROW_NONE) begin
          emit = 1'b1;
          rec_d.unknown_type = 1'b1;
        end else if (body_length == 16'd1) begin
          emit = 1'b1;
          rec_d.truncated = 1'b1;
        end
        phase_next = (body_length == 16'd1) ? itch_pkg::PH_LEN_HI : itch_pkg::PH_BODY;
      end
      default: begin
        byte_count_next = cnt;
        if (row != itch_pkg::ROW_NONE && field_number < n) begin
          field_accum_next    = acc;
          field_byte_pos_next = pos;
          rec_d.field_index = field_number;
          rec_d.field_value = acc;
          if (pos >= w) begin
            emit = 1'b1;
            rec_d.field_bytes = w;
            rec_d.last_field  = !more || fin;
            rec_d.truncated   = fin && more;
            field_number_next   = field_number + 5'd1;
            field_byte_pos_next = '0;
            field_accum_next    = '0;
          end else if (fin) begin
            emit = 1'b1;
            rec_d.field_bytes = pos;
            rec_d.last_field  = 1'b1;
            rec_d.truncated   = 1'b1;
          end
        end
        if (fin) begin
          phase_next          = itch_pkg::PH_LEN_HI;
          field_number_next   = '0;
          field_byte_pos_next = '0;
          field_accum_next    = '0;
        end
      end
    endcase
  end

  // Advance state on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= itch_pkg::PH_LEN_HI;
      body_length    <= '0;
      byte_count     <= '0;
      current_type   <= '0;
      row            <= itch_pkg::ROW_NONE;
      field_number   <= '0;
      field_byte_pos <= '0;
      field_accum    <= '0;
      rec_valid      <= 1'b0;
    end else begin
      rec_valid <= in_valid && emit;
      if (in_valid) begin
        phase          <= phase_next;
        body_length    <= body_length_next;
        byte_count     <= byte_count_next;
        current_type   <= current_type_next;
        row            <= row_next;
        field_number   <= field_number_next;
        field_byte_pos <= field_byte_pos_next;
        field_accum    <= field_accum_next;
      end
    end
  end

  // Hold the record for the queue.
  always_ff @(posedge clk) begin
    if (in_valid && emit) rec <= rec_d;
  end

endmodule
`default_nettype wire

// ===== hdl/itch_queue.sv =====
// Short queue between the front end and the output stage.
// Depends on itch_pkg.
`default_nettype none
module itch_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  itch_pkg::field_t wr_data,
  input  wire logic        rd_en,
  output logic             not_empty,
  output itch_pkg::field_t rd_data,
  output logic             almost_full
);

  localparam int AW = $clog2(DEPTH);

  itch_pkg::field_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign not_empty   = (count != '0);
  assign rd_data     = mem[rd_ptr];
  // Leave room for two requests still in flight from the front end.
  assign almost_full = (count >= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/itch_back.sv =====
// Output stage: moves records from the queue into a registered result port.
// Depends on itch_pkg.
`default_nettype none
module itch_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_not_empty,
  input  itch_pkg::field_t q_data,
  output logic             q_rd,
  output logic             out_valid,
  input  wire logic        out_stall,
  output itch_pkg::field_t out_rec
);

  // Load when the output register is free or being taken.
  assign q_rd = q_not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) out_rec <= q_data;
  end

endmodule
`default_nettype wire

// ===== hdl/itch_message_field_parser_top.sv =====
// Feed message field parser: one byte accepted per cycle, one result per field.
// Path of a result: front-end record register, record queue, output register.
// Throughput: one byte per cycle; in_stall rises only when the 4-entry record
// queue nears full because the output side is stalling.
// Reset (rst, synchronous): expect a length high byte, queue and output empty.
// Depends on itch_pkg, itch_front, itch_queue, itch_back.
`default_nettype none
module itch_message_field_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       msg_type,
  output logic [4:0]       field_index,
  output logic [63:0]      field_value,
  output logic [3:0]       field_bytes,
  output logic             last_field,
  output logic             unknown_type,
  output logic             truncated
);

  logic             rec_valid, q_ne, q_rd, q_af;
  itch_pkg::field_t rec, q_data, out_rec;

  assign in_stall = q_af;

  itch_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid && !in_stall), .in_byte(data_byte),
    .rec_valid(rec_valid), .rec(rec)
  );

  itch_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr_en(rec_valid), .wr_data(rec), .rd_en(q_rd),
    .not_empty(q_ne), .rd_data(q_data), .almost_full(q_af)
  );

  itch_back u_back (
    .clk(clk), .rst(rst), .q_not_empty(q_ne), .q_data(q_data), .q_rd(q_rd),
    .out_valid(out_valid), .out_stall(out_stall), .out_rec(out_rec)
  );

  assign msg_type     = out_rec.msg_type;
  assign field_index  = out_rec.field_index;
  assign field_value  = out_rec.field_value;
  assign field_bytes  = out_rec.field_bytes;
  assign last_field   = out_rec.last_field;
  assign unknown_type = out_rec.unknown_type;
  assign truncated    = out_rec.truncated;

endmodule
`default_nettype wire

// ===== hdl/itch_checker.sv =====
// Port-level checker for the feed parser, bound to the top level.
// Depends on itch_message_field_parser_top ports only.
`default_nettype none
module itch_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [4:0]  field_index,
  input wire logic [3:0]  field_bytes,
  input wire logic        last_field,
  input wire logic        unknown_type,
  input wire logic        truncated
);

  // Hold a stalled request.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_index) && $stable(field_bytes))
    else $error("stalled result changed");

  // Flag an unknown marker only as a lone empty last result.
  a_unk: assert property (@(posedge clk) disable iff (rst)
    out_valid && unknown_type |-> last_field && field_bytes == 4'd0 && field_index == 5'd0
      && !truncated)
    else $error("bad unknown marker");

  // Drop truncation only on a last result.
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated |-> last_field && !unknown_type)
    else $error("truncated result not last");

  // Keep field index and width in range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> field_index <= 5'd16 && field_bytes <= 4'd8)
    else $error("field out of range");

endmodule

bind itch_message_field_parser_top itch_checker u_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall), .field_index(field_index),
  .field_bytes(field_bytes), .last_field(last_field), .unknown_type(unknown_type),
  .truncated(truncated)
);
`default_nettype wire
